[sv/dtps_pkg.sv]
// Shared types and constants for the depth-tested pixel store.
// No dependencies; imported by the top level.
package dtps_pkg;

   // Field widths fixed by the interface
   localparam int COORD_BITS      = 12;
   localparam int SIZE_BITS       = 9;
   localparam int SIZE_LIMIT_BITS = 13;
   localparam int DEPTH_BITS      = 16;
   localparam int COLOR_BITS      = 8;
   localparam int PIXEL_BITS      = DEPTH_BITS + 3 * COLOR_BITS;

   // Remainder unit: bits retired per cycle and cycles per coordinate
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = COORD_BITS / DIV_STEP_BITS;
   localparam int DIV_CNT_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // Default frame store dimensions
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   typedef logic [0:0]                    cmd_type;
   typedef logic [0:0]                    csr_index_type;
   typedef logic [COORD_BITS-1:0]         coord_type;
   typedef logic [SIZE_BITS-1:0]          size_type;
   typedef logic signed [DEPTH_BITS-1:0]  depth_type;
   typedef logic [COLOR_BITS-1:0]         color_type;
   typedef logic [PIXEL_BITS-1:0]         pixel_type;

   localparam cmd_type CMD_WRITE = 1'b0;
   localparam cmd_type CMD_READ  = 1'b1;

   localparam csr_index_type REG_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type REG_FRAME_HEIGHT = 1'b1;

   localparam size_type  SIZE_RESET  = 9'd256;
   localparam depth_type DEPTH_RESET = 16'sh8000;   // -2.0 in Q2.14
   localparam color_type COLOR_RESET = 8'd0;

endpackage

[sv/dtps_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies; used for the pixel store.
module dtps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/depth_tested_pixel_store.sv]
// Depth-tested pixel store: frame buffer with a "greater wins" z test.
// Depends on dtps_pkg and dtps_ram.
//
// Each accepted request beat is a depth-tested write or a read of one pixel and
// yields exactly one response beat with the pixel's depth and color after the
// beat, plus an updated flag for writes that won the depth test (new depth
// strictly greater than stored, signed Q2.14). Coordinates wrap modulo the
// effective frame size (0 acts as 1, sizes clamp to MAX_WIDTH / MAX_HEIGHT);
// the row stride equals the effective width. Depth and color share one
// 40-bit-wide single-port RAM of MAX_WIDTH*MAX_HEIGHT entries. After reset the
// block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (65536 at the
// defaults), writing -2.0 and black to every pixel; req_stall stays high
// during that pass while CSR writes are taken as usual. Items are processed
// one at a time: accept, the x and y remainder units working side by side and
// retiring 4 dividend bits per cycle each, row multiply, address add plus RAM
// read, then test and write-back, where the response register loads. The
// response register decouples the sides: a new request is taken while a
// finished response waits; only the test/write-back step holds off when that
// register is still full and stalled. Frame size registers must be changed
// only while the block is idle.
module depth_tested_pixel_store #(
   parameter int MAX_WIDTH  = dtps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dtps_pkg::DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,

   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dtps_pkg::cmd_type       req_cmd,
   input  dtps_pkg::coord_type     req_pos_x,
   input  dtps_pkg::coord_type     req_pos_y,
   input  dtps_pkg::depth_type     req_new_depth,
   input  dtps_pkg::color_type     req_new_red,
   input  dtps_pkg::color_type     req_new_green,
   input  dtps_pkg::color_type     req_new_blue,

   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dtps_pkg::depth_type     rsp_stored_depth,
   output dtps_pkg::color_type     rsp_stored_red,
   output dtps_pkg::color_type     rsp_stored_green,
   output dtps_pkg::color_type     rsp_stored_blue,
   output logic                    rsp_updated,

   // CSR write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  dtps_pkg::csr_index_type csr_index,
   input  dtps_pkg::size_type      csr_data
);

   import dtps_pkg::*;

   localparam int PIXEL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int PROD_BITS   = 2 * SIZE_BITS;

   localparam logic [SIZE_LIMIT_BITS-1:0] MAX_W_V = SIZE_LIMIT_BITS'(MAX_WIDTH);
   localparam logic [SIZE_LIMIT_BITS-1:0] MAX_H_V = SIZE_LIMIT_BITS'(MAX_HEIGHT);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(PIXEL_COUNT - 1);
   localparam logic [DIV_CNT_BITS-1:0] LAST_DIV = DIV_CNT_BITS'(DIV_CYCLES - 1);
   localparam pixel_type PIXEL_RESET = {DEPTH_RESET, COLOR_RESET, COLOR_RESET, COLOR_RESET};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ADDR,
      ST_TEST
   } state_type;

   // zero acts as one, oversize clamps to the store limit
   function automatic size_type eff_size(size_type reg_val,
                                         logic [SIZE_LIMIT_BITS-1:0] limit);
      logic [SIZE_LIMIT_BITS-1:0] wide;
      wide = SIZE_LIMIT_BITS'(reg_val);
      if (reg_val == '0) begin
         return SIZE_BITS'(1);
      end else if (wide > limit) begin
         return limit[SIZE_BITS-1:0];
      end
      return reg_val;
   endfunction

   // ---------------------------------------------------------------- registers
   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   size_type                frame_width_ff, frame_width_in;
   size_type                frame_height_ff, frame_height_in;

   cmd_type                 cmd_ff, cmd_in;
   coord_type               x_ff, x_in;        // dividend, shifted out MSB first
   coord_type               y_ff, y_in;
   size_type                rx_ff, rx_in;      // partial remainders
   size_type                ry_ff, ry_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in;
   pixel_type               frag_ff, frag_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   depth_type               rsp_depth_ff, rsp_depth_in;
   color_type               rsp_red_ff, rsp_red_in;
   color_type               rsp_green_ff, rsp_green_in;
   color_type               rsp_blue_ff, rsp_blue_in;
   logic                    rsp_upd_ff, rsp_upd_in;

   // ---------------------------------------------------------------- RAM port
   logic                    ram_en;
   logic                    ram_we;
   logic [ADDR_BITS-1:0]    ram_addr;
   pixel_type               ram_wdata;
   pixel_type               ram_rdata;

   dtps_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (PIXEL_COUNT)
   ) u_pixel_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------- datapath
   size_type                w_eff;
   size_type                h_eff;
   logic                    req_take;
   logic                    rsp_take;
   logic                    rsp_free;
   logic [SIZE_BITS:0]      tx;
   logic [SIZE_BITS:0]      ty;
   size_type                rx_next;
   size_type                ry_next;
   logic [PROD_BITS:0]      addr_sum;
   depth_type               stored_depth;
   depth_type               frag_depth;
   logic                    pass;

   assign w_eff = eff_size(frame_width_ff, MAX_W_V);
   assign h_eff = eff_size(frame_height_ff, MAX_H_V);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // restoring remainder, DIV_STEP_BITS dividend bits per cycle for x and y
   always_comb begin
      rx_next = rx_ff;
      ry_next = ry_ff;
      tx      = '0;
      ty      = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         tx = {rx_next, x_ff[COORD_BITS-1-i]};
         if (tx >= {1'b0, w_eff}) begin
            tx = tx - {1'b0, w_eff};
         end
         rx_next = tx[SIZE_BITS-1:0];
         ty = {ry_next, y_ff[COORD_BITS-1-i]};
         if (ty >= {1'b0, h_eff}) begin
            ty = ty - {1'b0, h_eff};
         end
         ry_next = ty[SIZE_BITS-1:0];
      end
   end

   // y*w + x stays below the store size by construction
   assign addr_sum     = (PROD_BITS+1)'(prod_ff) + (PROD_BITS+1)'(rx_ff);
   assign stored_depth = ram_rdata[PIXEL_BITS-1 -: DEPTH_BITS];
   assign frag_depth   = frag_ff[PIXEL_BITS-1 -: DEPTH_BITS];
   assign pass         = (cmd_ff == CMD_WRITE) && (frag_depth > stored_depth);

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      div_cnt_in      = div_cnt_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      cmd_in          = cmd_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      rx_in           = rx_ff;
      ry_in           = ry_ff;
      prod_in         = prod_ff;
      addr_in         = addr_ff;
      frag_in         = frag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_take;
      rsp_depth_in    = rsp_depth_ff;
      rsp_red_in      = rsp_red_ff;
      rsp_green_in    = rsp_green_ff;
      rsp_blue_in     = rsp_blue_ff;
      rsp_upd_in      = rsp_upd_ff;
      ram_en          = 1'b0;
      ram_we          = 1'b0;
      ram_addr        = addr_ff;
      ram_wdata       = frag_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_data;
            REG_FRAME_HEIGHT: frame_height_in = csr_data;
            default:          frame_width_in  = frame_width_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            ram_wdata   = PIXEL_RESET;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in     = req_cmd;
               x_in       = req_pos_x;
               y_in       = req_pos_y;
               rx_in      = '0;
               ry_in      = '0;
               div_cnt_in = '0;
               frag_in    = {req_new_depth, req_new_red, req_new_green, req_new_blue};
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rx_in      = rx_next;
            ry_in      = ry_next;
            x_in       = x_ff << DIV_STEP_BITS;
            y_in       = y_ff << DIV_STEP_BITS;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == LAST_DIV) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ry_ff * w_eff;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            addr_in  = ADDR_BITS'(addr_sum);
            ram_en   = 1'b1;
            ram_addr = ADDR_BITS'(addr_sum);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            // wait here while the response register is full and stalled
            if (rsp_free) begin
               ram_en       = pass;
               ram_we       = pass;
               rsp_valid_in = 1'b1;
               rsp_upd_in   = pass;
               if (pass) begin
                  {rsp_depth_in, rsp_red_in, rsp_green_in, rsp_blue_in} = frag_ff;
               end else begin
                  {rsp_depth_in, rsp_red_in, rsp_green_in, rsp_blue_in} = ram_rdata;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         div_cnt_ff      <= '0;
         frame_width_ff  <= SIZE_RESET;
         frame_height_ff <= SIZE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         div_cnt_ff      <= div_cnt_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      prod_ff      <= prod_in;
      addr_ff      <= addr_in;
      frag_ff      <= frag_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stored_depth = rsp_depth_ff;
   assign rsp_stored_red   = rsp_red_ff;
   assign rsp_stored_green = rsp_green_ff;
   assign rsp_stored_blue  = rsp_blue_ff;
   assign rsp_updated      = rsp_upd_ff;

endmodule

[tb/sv/tb_depth_tested_pixel_store.sv]
// Self-checking testbench for depth_tested_pixel_store: a frame-model predictor
// with random idle and stall on both channels. Depends on dtps_pkg and the RTL.
module tb_depth_tested_pixel_store;
   import dtps_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int TIMEOUT_CYCLES = 1_500_000;   // clearing pass + ~1.5k beats, many times over
   localparam int FRAME_W_MAX    = DEF_MAX_WIDTH;
   localparam int FRAME_H_MAX    = DEF_MAX_HEIGHT;
   localparam int PIXELS         = FRAME_W_MAX * FRAME_H_MAX;
   localparam depth_type DEPTH_NEAREST = 16'sh7fff;   // just under +2.0

   typedef struct {
      cmd_type   cmd;
      coord_type pos_x;
      coord_type pos_y;
      depth_type depth;
      color_type red;
      color_type green;
      color_type blue;
   } pixel_op_type;

   typedef struct {
      depth_type depth;
      color_type red;
      color_type green;
      color_type blue;
      logic      updated;
   } pixel_result_type;

   // DUT-facing signals; every input starts at a known value
   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   cmd_type   req_cmd = CMD_WRITE;
   coord_type req_pos_x = '0;
   coord_type req_pos_y = '0;
   depth_type req_new_depth = '0;
   color_type req_new_red = '0;
   color_type req_new_green = '0;
   color_type req_new_blue = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   depth_type rsp_stored_depth;
   color_type rsp_stored_red;
   color_type rsp_stored_green;
   color_type rsp_stored_blue;
   logic      rsp_updated;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_FRAME_WIDTH;
   size_type      csr_data = '0;

   // Frame model: our own copy of the z buffer, color buffer and frame size
   depth_type   z_mem   [PIXELS];
   logic [23:0] rgb_mem [PIXELS];
   size_type    frame_w_cfg = SIZE_RESET;
   size_type    frame_h_cfg = SIZE_RESET;

   pixel_result_type expected_pixels[$];   // one entry per accepted request beat, oldest first
   int            error_count = 0;
   int unsigned   hold_request = 0;     // >0 asks the receiver for one long stall
   bit            quiet_sender = 1'b0;  // back-to-back requests while set

   depth_tested_pixel_store dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_new_depth    (req_new_depth),
      .req_new_red      (req_new_red),
      .req_new_green    (req_new_green),
      .req_new_blue     (req_new_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_stored_depth (rsp_stored_depth),
      .rsp_stored_red   (rsp_stored_red),
      .rsp_stored_green (rsp_stored_green),
      .rsp_stored_blue  (rsp_stored_blue),
      .rsp_updated      (rsp_updated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the block hangs (clearing pass never ends, lost beat, ...)
   initial begin
      #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
      $display("[depth_tested_pixel_store] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // Register value -> size actually used: 0 acts as 1, oversize clamps
   function automatic int unsigned dim_in_use(input size_type reg_v, input int unsigned lim);
      if (reg_v == 0) return 1;
      if (32'(reg_v) > lim) return lim;
      return 32'(reg_v);
   endfunction

   // Wrap both coordinates, then row-major with stride = width in use
   function automatic int unsigned pixel_index(input coord_type x, input coord_type y);
      int unsigned w, h, xu, yu;
      w  = dim_in_use(frame_w_cfg, FRAME_W_MAX);
      h  = dim_in_use(frame_h_cfg, FRAME_H_MAX);
      xu = 32'(x);
      yu = 32'(y);
      return (yu % h) * w + (xu % w);
   endfunction

   function automatic void clear_frame_model();
      for (int i = 0; i < PIXELS; i++) begin
         z_mem[i]   = DEPTH_RESET;
         rgb_mem[i] = '0;
      end
   endfunction

   // Greater-wins depth test; updates the model and returns the pixel afterwards.
   // Equal depth loses, so a -2.0 write never lands on a cleared pixel.
   function automatic pixel_result_type z_test_and_store(input pixel_op_type op);
      pixel_result_type res;
      int unsigned   a;
      a = pixel_index(op.pos_x, op.pos_y);
      res.updated = 1'b0;
      if (op.cmd == CMD_WRITE && op.depth > z_mem[a]) begin
         z_mem[a]    = op.depth;
         rgb_mem[a]  = {op.red, op.green, op.blue};
         res.updated = 1'b1;
      end
      res.depth = z_mem[a];
      {res.red, res.green, res.blue} = rgb_mem[a];
      return res;
   endfunction

   // ---------------------------------------------------------------- request side

   function automatic int unsigned pick_sender_gap();
      int unsigned pick;
      if (quiet_sender) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offers one beat and waits for it to be taken. Valid is left high on
   // return; the caller either sends again in the same step or drains.
   task automatic send_pixel_op(input pixel_op_type op);
      int unsigned gap;
      gap = pick_sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= op.cmd;
      req_pos_x     <= op.pos_x;
      req_pos_y     <= op.pos_y;
      req_new_depth <= op.depth;
      req_new_red   <= op.red;
      req_new_green <= op.green;
      req_new_blue  <= op.blue;
      do @(posedge clock); while (!(req_valid && !req_stall));
      expected_pixels.push_back(z_test_and_store(op));
   endtask

   task automatic send_write(input coord_type x, input coord_type y, input depth_type d,
                             input color_type r, input color_type g, input color_type b);
      pixel_op_type op;
      op = '{CMD_WRITE, x, y, d, r, g, b};
      send_pixel_op(op);
   endtask

   // Fragment fields of a read are don't-care for the block: fill with noise
   task automatic send_read(input coord_type x, input coord_type y);
      pixel_op_type op;
      op = '{CMD_READ, x, y, depth_type'($urandom), color_type'($urandom),
             color_type'($urandom), color_type'($urandom)};
      send_pixel_op(op);
   endtask

   // Sender goes quiet until every expected beat is back, then lets the
   // pipeline settle before anything touches the CSRs.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both size registers in one burst; valid stays high between the two beats
   task automatic set_frame_size(input size_type width_v, input size_type height_v);
      csr_valid <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= width_v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      frame_w_cfg = width_v;
      csr_index <= REG_FRAME_HEIGHT;
      csr_data  <= height_v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      frame_h_cfg = height_v;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- response side

   // Receiver stall pattern: calm stretches, short flicker, occasional long
   // stall, and on request one very long hold to back the block up.
   initial begin : receiver_stall
      int unsigned run_left;
      int unsigned pick;
      logic        run_level;
      run_left  = 0;
      run_level = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            run_level    = 1'b1;
            run_left     = hold_request;
            hold_request = 0;
         end else if (run_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               run_level = 1'b0;
               run_left  = $urandom_range(20, 80);
            end else if (pick < 24) begin
               run_level = 1'b1;
               run_left  = $urandom_range(12, 40);
            end else begin
               run_level = 1'($urandom_range(0, 1));
               run_left  = $urandom_range(1, 3);
            end
         end
         rsp_stall <= run_level;
         run_left--;
      end
   end

   // Every response beat is matched against the oldest expectation
   always @(posedge clock) begin : check_beat
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_stored_depth !== want.depth) begin
               $error("stored_depth: expected %0d, got %0d", want.depth, rsp_stored_depth);
               error_count++;
            end
            if (rsp_stored_red !== want.red) begin
               $error("stored_red: expected %0d, got %0d", want.red, rsp_stored_red);
               error_count++;
            end
            if (rsp_stored_green !== want.green) begin
               $error("stored_green: expected %0d, got %0d", want.green, rsp_stored_green);
               error_count++;
            end
            if (rsp_stored_blue !== want.blue) begin
               $error("stored_blue: expected %0d, got %0d", want.blue, rsp_stored_blue);
               error_count++;
            end
            if (rsp_updated !== want.updated) begin
               $error("updated: expected %0d, got %0d", want.updated, rsp_updated);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Default 256x256 frame right after the clearing pass
   task automatic test_fresh_pixels();
      send_read(0, 0);                                  // cleared: -2.0, black
      send_write(0, 0, DEPTH_RESET, 8'hff, 8'hff, 8'hff); // -2.0 vs -2.0 loses
      send_write(0, 0, -16'sd32767, 8'hff, 8'hff, 8'hff);
      send_write(0, 0, -16'sd32767, 8'h12, 8'h34, 8'h56); // tie loses
      send_write(255, 255, DEPTH_NEAREST, 8'haa, 8'h55, 8'h0f);
      send_read(12'hfff, 12'hfff);                      // wraps onto (255,255)
      send_write(256, 0, 16'sd0, 8'h00, 8'h80, 8'h01);  // wraps onto (0,0)
      send_pixel_op('{CMD_READ, 12'hfff, 12'h000, DEPTH_NEAREST, 8'hff, 8'hff, 8'hff});
      send_write(255, 255, -16'sd1, 8'h01, 8'h02, 8'h03); // farther, rejected
   endtask

   // Zero and oversize sizes, odd sizes, and that contents survive a resize
   task automatic test_frame_sizes();
      wait_results_drained();
      set_frame_size(0, 0);                             // everything folds onto pixel 0
      send_write(123, 456, 16'sd5, 8'h11, 8'h22, 8'h33);
      send_read(12'hfff, 12'hfff);
      wait_results_drained();
      set_frame_size(511, 300);                         // both clamp to 256
      send_read(300, 300);
      send_write(300, 300, 16'sd100, 8'hc0, 8'h3c, 8'h03);
      wait_results_drained();
      set_frame_size(7, 3);
      send_read(0, 1);
      send_write(12'hfff, 12'hfff, 16'sd5, 8'hee, 8'hdd, 8'hcc); // pixel 0, tie
      wait_results_drained();
      set_frame_size(256, 1);
      send_write(255, 12'hfff, DEPTH_NEAREST, 8'h7f, 8'h80, 8'hfe);
      wait_results_drained();
      set_frame_size(1, 256);                           // same pixel through another stride
      send_read(12'hfff, 255);
      send_read(0, 255);
   endtask

   // Long receiver hold with the sender pushing back to back; then the sender
   // waits for every result before going on.
   task automatic test_backpressure();
      wait_results_drained();
      set_frame_size(4, 4);
      hold_request = 300;
      quiet_sender = 1'b1;
      for (int i = 0; i < 16; i++) send_pixel_op(random_pixel_op());
      quiet_sender = 1'b0;
      wait_results_drained();
   endtask

   function automatic size_type pick_frame_dim();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return size_type'($urandom_range(1, 12)); // small frames revisit pixels
      if (pick < 72) return size_type'(0);
      if (pick < 79) return size_type'(256);
      if (pick < 86) return size_type'($urandom_range(257, 511));
      return size_type'($urandom_range(13, 255));
   endfunction

   // Depth is aimed at the target pixel's current depth so ties, near misses
   // and just-wins come up often, with full-range values and extremes mixed in.
   function automatic pixel_op_type random_pixel_op();
      pixel_op_type op;
      int unsigned pick;
      depth_type   here;
      op.cmd   = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_WRITE;
      op.pos_x = coord_type'($urandom);
      op.pos_y = coord_type'($urandom);
      op.red   = color_type'($urandom);
      op.green = color_type'($urandom);
      op.blue  = color_type'($urandom);
      here = z_mem[pixel_index(op.pos_x, op.pos_y)];
      pick = $urandom_range(0, 99);
      if (pick < 35)      op.depth = depth_type'($urandom);
      else if (pick < 55) op.depth = here;
      else if (pick < 65) op.depth = here + 16'sd1;
      else if (pick < 75) op.depth = here - 16'sd1;
      else if (pick < 82) op.depth = DEPTH_NEAREST;
      else if (pick < 89) op.depth = DEPTH_RESET;
      else                op.depth = here + depth_type'($urandom_range(0, 64)) - 16'sd32;
      return op;
   endfunction

   // 15 frame sizes, 100 beats each, with a no-gap stretch in the middle
   task automatic test_random_frames();
      for (int phase = 0; phase < 15; phase++) begin
         wait_results_drained();
         set_frame_size(pick_frame_dim(), pick_frame_dim());
         for (int i = 0; i < 100; i++) begin
            quiet_sender = (i >= 40 && i < 60);
            send_pixel_op(random_pixel_op());
         end
         quiet_sender = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_frame_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // first beat is held off by the clearing pass
      test_fresh_pixels();
      test_frame_sizes();
      test_backpressure();
      test_random_frames();
      wait_results_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("[depth_tested_pixel_store] OK");
      end else begin
         $display("[depth_tested_pixel_store] ERROR");
      end
      $finish;
   end

endmodule
